[src/rrvg_pkg.sv]
// Package for the rounded rectangle vertex generator: register indexes,
// fixed-point constants and the CORDIC arctangent table. No dependencies.
package rrvg_pkg;

	localparam int LEN_FRAC = 9;
	localparam int OFF_FRAC = 4;
	localparam int CORDIC_STEPS = 28;
	localparam int CORDIC_GAIN30 = 652032874;

	typedef enum logic [2:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_RADIUS = 3'd2,
		REG_THICK  = 3'd3,
		REG_POINTS = 3'd4
	} reg_idx_t;

	// arctangent of 2^-i as a fraction of a turn, 2^32 per turn
	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] v;
		case (i)
			0: v = 32'd536870912;   1: v = 32'd316933406;
			2: v = 32'd167458907;   3: v = 32'd85004756;
			4: v = 32'd42667331;    5: v = 32'd21354465;
			6: v = 32'd10679838;    7: v = 32'd5340245;
			8: v = 32'd2670163;     9: v = 32'd1335087;
			10: v = 32'd667544;     11: v = 32'd333772;
			12: v = 32'd166886;     13: v = 32'd83443;
			14: v = 32'd41722;      15: v = 32'd20861;
			16: v = 32'd10430;      17: v = 32'd5215;
			18: v = 32'd2608;       19: v = 32'd1304;
			20: v = 32'd652;        21: v = 32'd326;
			22: v = 32'd163;        23: v = 32'd81;
			24: v = 32'd41;         25: v = 32'd20;
			26: v = 32'd10;         27: v = 32'd5;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

	// 1.5*t^0.8 with four fractional bits, rounded down, for whole-pixel t
	function automatic logic [10:0] outer_offset(input logic [7:0] t);
		logic [127:0] lim;
		logic [127:0] c5;
		logic [10:0] y;
		logic [10:0] c;
		begin
			lim = 128'(243) * 128'(t) * 128'(t) * 128'(t) * 128'(t) * (128'(1) << 20);
			y = '0;
			for (int b = 10; b >= 0; b--) begin
				c = y | (11'd1 << b);
				c5 = 128'(32) * 128'(c) * 128'(c) * 128'(c) * 128'(c) * 128'(c);
				if (c5 <= lim)
					y = c;
			end
			return y;
		end
	endfunction

	// outer offset table built at elaboration, indexed by thickness
	function automatic logic [10:0] offset_rom(input logic [7:0] t);
		logic [10:0] v;
		v = '0;
		for (int k = 0; k < 256; k++)
			if (t == 8'(k))
				v = outer_offset(8'(k));
		return v;
	endfunction

	// rounded-up reciprocal ceil(2^42/m) for divisors m of 1..63
	function automatic logic [42:0] recip_rom(input logic [5:0] m);
		logic [42:0] v;
		v = '0;
		for (int j = 1; j < 64; j++)
			if (m == 6'(j))
				v = 43'(((64'(1) << 42) + 64'(j) - 64'(1)) / 64'(j));
		return v;
	endfunction

endpackage

[src/rrvg_cordic.sv]
// Pipelined CORDIC rotator: one iteration per stage, quarter fold at the end.
// Depends on rrvg_pkg.
module rrvg_cordic import rrvg_pkg::*; #(
	parameter int TRIG_FRAC_BITS = 16,
	parameter int TAG_W = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_vld,
	input  logic [31:0]             phase,
	input  logic [TAG_W-1:0]        tag_in,
	output logic                    out_vld,
	output logic signed [TRIG_FRAC_BITS+2:0] cs,
	output logic signed [TRIG_FRAC_BITS+2:0] sn,
	output logic [TAG_W-1:0]        tag_out
);
	localparam int XW = TRIG_FRAC_BITS + 3;
	localparam logic signed [XW-1:0] X0 = XW'((64'(CORDIC_GAIN30) +
		(64'(1) << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS));

	logic              vld_s [CORDIC_STEPS+1];
	logic signed [XW-1:0] x_s [CORDIC_STEPS+1];
	logic signed [XW-1:0] y_s [CORDIC_STEPS+1];
	logic signed [32:0]   z_s [CORDIC_STEPS+1];
	logic [1:0]           q_s [CORDIC_STEPS+1];
	logic [TAG_W-1:0]     t_s [CORDIC_STEPS+1];

	always_comb begin
		vld_s[0] = in_vld;
		x_s[0] = X0;
		y_s[0] = '0;
		z_s[0] = {3'b000, phase[29:0]};
		q_s[0] = phase[31:30];
		t_s[0] = tag_in;
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_it
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (!z_s[i][32]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - $signed({1'b0, atan_turn(i)});
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + $signed({1'b0, atan_turn(i)});
			end
			q_s[i+1] <= q_s[i];
			t_s[i+1] <= t_s[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= vld_s[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		tag_out <= t_s[CORDIC_STEPS];
		case (q_s[CORDIC_STEPS])
			2'd0: begin cs <= x_s[CORDIC_STEPS]; sn <= y_s[CORDIC_STEPS]; end
			2'd1: begin cs <= -y_s[CORDIC_STEPS]; sn <= x_s[CORDIC_STEPS]; end
			2'd2: begin cs <= -x_s[CORDIC_STEPS]; sn <= -y_s[CORDIC_STEPS]; end
			default: begin cs <= y_s[CORDIC_STEPS]; sn <= -x_s[CORDIC_STEPS]; end
		endcase
	end
endmodule

[src/rounded_rect_vertex_gen_top.sv]
// Top level of the rounded rectangle vertex generator: configuration
// registers, geometry and phase stages, output scaling. Uses rrvg_pkg, rrvg_cordic.
//
//  channel   | handshake            | payload
//  ----------+----------------------+----------------------------------
//  command   | start / busy         | op, vertex_index
//  config    | cfg_valid / cfg_ready| cfg_index, cfg_data
//  result    | done (strobe)        | x_pos, y_pos, index_error
//
// One vertex per cycle. The pipeline has three front stages (clamp,
// corner and phase numerator, phase divide), 28 CORDIC stages plus the
// quadrant fold, two multiply stages and one output register. busy stays
// low; the receiver cannot stall, so the pipeline always advances.
// Reset clears the valid bits and loads the register reset values.
module rounded_rect_vertex_gen_top import rrvg_pkg::*; #(
	parameter int MAX_POINTS = 64,
	parameter int COORD_FRAC_BITS = 4,
	parameter int TRIG_FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               op,
	input  logic [5:0]         vertex_index,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [11:0]        cfg_data,
	output logic               done,
	output logic signed [17:0] x_pos,
	output logic signed [17:0] y_pos,
	output logic               index_error
);
	localparam int PMAX = (MAX_POINTS / 4) * 4;
	localparam int TW = TRIG_FRAC_BITS + 3;
	// length words: 12 integer bits + 9 fraction, signed headroom
	localparam int LW = 24;

	logic [11:0] width_q, height_q;
	logic [10:0] radius_q;
	logic [7:0]  thick_q;
	logic [6:0]  points_q;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 12'd64;
			height_q <= 12'd32;
			radius_q <= 11'd8;
			thick_q <= 8'd0;
			points_q <= 7'd32;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WIDTH:  width_q <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_RADIUS: radius_q <= cfg_data[10:0];
				REG_THICK:  thick_q <= cfg_data[7:0];
				REG_POINTS: points_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Stage 1: effective point count, radius, thickness
	logic [8:0] p_raw, p_c;
	logic [11:0] hw, hh, hmin, r_c, t_room, t_c;
	always_comb begin
		p_raw = ((9'(points_q) + 9'd3) >> 2) << 2;
		p_c = p_raw;
		if (p_c < 9'd8) p_c = 9'd8;
		if (p_c > 9'(PMAX)) p_c = 9'(PMAX);
		// half sizes in 1/2 pixel: keep as pixels*2 to stay exact
		hw = width_q;
		hh = height_q;
		hmin = (hw < hh) ? hw : hh;
		r_c = ({radius_q, 1'b0} < hmin) ? {radius_q, 1'b0} : hmin;
		t_room = hmin - r_c;
		t_c = ({3'b0, thick_q, 1'b0} < t_room) ? {3'b0, thick_q, 1'b0} : t_room;
	end

	logic        vld_s1, op_s1, err_s1;
	logic [5:0]  idx_s1;
	logic [8:0]  p_s1;
	logic [11:0] r2_s1, t2_s1;
	logic [11:0] w_s1, h_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= start;
	end
	always_ff @(posedge clk) begin
		op_s1 <= op;
		idx_s1 <= vertex_index;
		err_s1 <= (9'(vertex_index) >= p_c);
		p_s1 <= p_c;
		r2_s1 <= r_c;
		t2_s1 <= t_c;
		w_s1 <= width_q;
		h_s1 <= height_q;
	end

	// Stage 2: corner, k, lengths (units 2^-9 pixel, from doubled values)
	logic [1:0] corner;
	logic [5:0] k;
	logic [LW-1:0] r_l, t_l, tr_l, arc_l, o_l;
	always_comb begin
		corner = 2'd3;
		for (int c = 3; c >= 1; c--)
			if ({2'b0, idx_s1, 2'b0} < 10'(p_s1) * 10'(c)) corner = 2'(c - 1);
		k = idx_s1 - 6'(corner);
		r_l = LW'(r2_s1) << (LEN_FRAC - 1);
		t_l = LW'(t2_s1) << (LEN_FRAC - 1);
		o_l = LW'(offset_rom(t2_s1[8:1])) << (LEN_FRAC - OFF_FRAC);
		tr_l = op_s1 ? r_l + o_l : r_l + t_l;
		arc_l = op_s1 ? tr_l : r_l;
	end

	localparam int TAGW = 1 + 2 + 2*LW + 24;
	logic        vld_s2, err_s2;
	logic [1:0]  cor_s2;
	logic [5:0]  k_s2;
	logic [5:0]  m_s2;
	logic [LW-1:0] tr_s2, arc_s2;
	logic [11:0] w_s2, h_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else vld_s2 <= vld_s1;
	end
	always_ff @(posedge clk) begin
		err_s2 <= err_s1;
		cor_s2 <= corner;
		k_s2 <= k;
		m_s2 <= 6'((p_s1 - 9'd4) >> 2);
		tr_s2 <= tr_l;
		arc_s2 <= arc_l;
		w_s2 <= w_s1;
		h_s2 <= h_s1;
	end

	// Stage 3: phase = floor(k*2^32/den) with den = 4*m, m below 64, k <= den,
	// so phase = floor(k*2^30/m). Multiply k by the rounded-up reciprocal
	// 2^42/m and drop 12 bits: the excess stays below one unit for every k.
	// k equal to den wraps to a zero phase, as the 32-bit turn fraction does.
	logic [48:0] ph_prod;
	logic [31:0] phase;
	always_comb begin
		ph_prod = 49'(k_s2) * 49'(recip_rom(m_s2));
		phase = ph_prod[43:12];
	end

	logic vld_s3;
	logic [31:0] ph_s3;
	logic [TAGW-1:0] tag_s3, tag_c;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else vld_s3 <= vld_s2;
	end
	always_ff @(posedge clk) begin
		ph_s3 <= phase;
		tag_s3 <= {err_s2, cor_s2, tr_s2, arc_s2, w_s2, h_s2};
	end

	logic vld_c;
	logic signed [TW-1:0] cs_c, sn_c;
	rrvg_cordic #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS), .TAG_W(TAGW)) u_cordic (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s3), .phase(ph_s3),
		.tag_in(tag_s3), .out_vld(vld_c), .cs(cs_c), .sn(sn_c), .tag_out(tag_c)
	);

	logic c_err;
	logic [1:0] c_cor;
	logic [LW-1:0] c_tr, c_arc;
	logic [11:0] c_w, c_h;
	assign {c_err, c_cor, c_tr, c_arc, c_w, c_h} = tag_c;

	// Stage M1: trig products
	localparam int PW = TW + LW + 1;
	logic vld_m1, err_m1;
	logic signed [PW-1:0] px_m1, py_m1;
	logic signed [LW+1:0] bx_m1, by_m1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_m1 <= 1'b0;
		else vld_m1 <= vld_c;
	end
	always_ff @(posedge clk) begin
		err_m1 <= c_err;
		px_m1 <= PW'(cs_c) * $signed({1'b0, c_arc});
		py_m1 <= PW'(sn_c) * $signed({1'b0, c_arc});
		bx_m1 <= $signed({2'b0, c_tr}) + (((c_cor == 2'd1) || (c_cor == 2'd2)) ?
			$signed({2'b0, LW'(c_w) << LEN_FRAC}) - $signed({1'b0, c_tr, 1'b0}) : '0);
		by_m1 <= $signed({2'b0, c_tr}) + (c_cor[1] ?
			$signed({2'b0, LW'(c_h) << LEN_FRAC}) - $signed({1'b0, c_tr, 1'b0}) : '0);
	end

	// Stage M2: round products, subtract
	logic signed [PW-1:0] rx, ry;
	assign rx = (px_m1 + (PW'(1) <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
	assign ry = (py_m1 + (PW'(1) <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;

	logic vld_m2, err_m2;
	logic signed [LW+2:0] x_m2, y_m2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_m2 <= 1'b0;
		else vld_m2 <= vld_m1;
	end
	always_ff @(posedge clk) begin
		err_m2 <= err_m1;
		x_m2 <= (LW+3)'(bx_m1) - (LW+3)'(rx);
		y_m2 <= (LW+3)'(by_m1) - (LW+3)'(ry);
	end

	// Output: round to coordinate fraction, saturate, zero on bad index
	localparam int SH = LEN_FRAC - COORD_FRAC_BITS;
	function automatic logic signed [17:0] to_out(input logic signed [LW+2:0] v);
		logic signed [LW+3:0] r;
		r = ((LW+4)'(v) + ((LW+4)'(1) <<< (SH - 1))) >>> SH;
		if (r > (LW+4)'(131071)) return 18'sd131071;
		if (r < -(LW+4)'(131072)) return -18'sd131072;
		return r[17:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= vld_m2;
	end
	always_ff @(posedge clk) begin
		index_error <= err_m2;
		x_pos <= err_m2 ? '0 : to_out(x_m2);
		y_pos <= err_m2 ? '0 : to_out(y_m2);
	end
endmodule
